// File: hdl/cfm_pkg.sv
// Shared types, codes and thresholds for the contactor fault monitor.
// Used by every module of the block; depends on nothing else.
package cfm_pkg;

   // Check phase codes carried in the cmd field.
   localparam logic [2:0] CMD_PART1     = 3'd0;
   localparam logic [2:0] CMD_PART2     = 3'd1;
   localparam logic [2:0] CMD_PART3     = 3'd2;
   localparam logic [2:0] CMD_PRECHARGE = 3'd3;
   localparam logic [2:0] CMD_POS_TEST  = 3'd4;

   // Phase time windows in milliseconds.
   localparam logic [15:0] T_WIN_START = 16'd60;
   localparam logic [15:0] T_PART1_END = 16'd350;
   localparam logic [15:0] T_MID       = 16'd400;
   localparam logic [15:0] T_PART2_END = 16'd600;

   // Pack power-up state codes.
   localparam logic [7:0] SC_POS_WELD  = 8'd17;
   localparam logic [7:0] SC_PANT_WELD = 8'd87;
   localparam logic [7:0] SC_DC_WELD   = 8'd147;
   localparam logic [7:0] SC_POS_OPEN  = 8'd20;
   localparam logic [7:0] SC_PANT_OPEN = 8'd90;
   localparam logic [7:0] SC_DC_OPEN   = 8'd150;

   // Debounce counter slots.
   localparam int NUM_CNT      = 11;
   localparam int CNT_MSD      = 0;
   localparam int CNT_NWELD    = 1;
   localparam int CNT_NOPEN    = 2;
   localparam int CNT_PWELD    = 3;
   localparam int CNT_PANTWELD = 4;
   localparam int CNT_DCWELD   = 5;
   localparam int CNT_POPEN    = 6;
   localparam int CNT_PANTOPEN = 7;
   localparam int CNT_DCOPEN   = 8;
   localparam int CNT_PRE      = 9;
   localparam int CNT_PTEST    = 10;

   // Fault flag bit positions.
   localparam int F_MSD      = 0;
   localparam int F_NWELD    = 1;
   localparam int F_NOPEN    = 2;
   localparam int F_PWELD    = 3;
   localparam int F_POPEN    = 4;
   localparam int F_PRE      = 5;
   localparam int F_PANTWELD = 6;
   localparam int F_DCWELD   = 7;
   localparam int F_PANTOPEN = 8;
   localparam int F_DCOPEN   = 9;

   // Contactor status bit positions.
   localparam int CT_NEG = 0;
   localparam int CT_POS = 1;
   localparam int CT_PRE = 3;

   // Status codes.
   localparam logic [1:0] STAGE_1     = 2'd1;
   localparam logic [1:0] STAGE_2     = 2'd2;
   localparam logic [1:0] STAGE_3     = 2'd3;
   localparam logic [1:0] PRE_PASSED  = 2'd1;
   localparam logic [1:0] PRE_WELD    = 2'd2;
   localparam logic [1:0] HV_NORMAL   = 2'd0;
   localparam logic [1:0] HV_INVALID  = 2'd3;

   // Configuration register indexes (byte address is four times the index).
   localparam logic [2:0] REG_DEBOUNCE_LIMIT = 3'd0;
   localparam logic [2:0] REG_MSD_MIN_VOLT   = 3'd1;
   localparam logic [2:0] REG_NEG_WELD_VOLT  = 3'd2;
   localparam logic [2:0] REG_OPEN_VOLT      = 3'd3;
   localparam logic [2:0] REG_POS_WELD_VOLT  = 3'd4;
   localparam logic [2:0] REG_CHG_WELD_VOLT  = 3'd5;
   localparam logic [2:0] REG_PRE_WELD_VOLT  = 3'd6;
   localparam logic [2:0] REG_POS_TEST_VOLT  = 3'd7;

   typedef struct packed {
      logic [3:0]  debounce_limit;
      logic [15:0] msd_min_volt;
      logic [15:0] neg_weld_volt;
      logic [15:0] open_volt;
      logic [15:0] pos_weld_volt;
      logic [15:0] charge_weld_volt;
      logic [15:0] pre_weld_volt;
      logic [15:0] pos_test_volt;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] elapsed_ms;
      logic [7:0]  state_code;
      logic [15:0] volt_v1;
      logic [15:0] volt_v2;
      logic [15:0] volt_v3;
      logic [15:0] volt_v2b;
      logic [15:0] volt_v3b;
   } item_type;

   typedef struct packed {
      logic [NUM_CNT-1:0][4:0] cnt;
      logic [9:0]              fault_bits;
      logic                    power_off;
      logic [3:0]              contactor;
      logic [1:0]              stage;
      logic [1:0]              precharge;
      logic [1:0]              hv;
   } state_type;

   typedef struct packed {
      logic [4:0] cnt;
      logic       hit;
   } qual_type;

   // One debounce step: a failing condition clears the counter, a counter
   // that reaches the limit latches and parks at limit plus one.
   function automatic qual_type qualify(input logic [4:0] cnt, input logic cond,
                                        input logic [3:0] limit);
      qual_type   r;
      logic [4:0] inc;
      r   = '0;
      inc = cnt + 5'd1;
      if (cond) begin
         if (inc >= {1'b0, limit}) begin
            r.cnt = {1'b0, limit} + 5'd1;
            r.hit = 1'b1;
         end else begin
            r.cnt = inc;
         end
      end
      return r;
   endfunction

endpackage

// File: hdl/cfm_csr.sv
// Configuration register file with its APB-style access port.
// Depends on cfm_pkg for the register indexes and the cfg_type bundle.
module cfm_csr
   import cfm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_DEBOUNCE_LIMIT: cfg_in.debounce_limit   = csr_pwdata[3:0];
            REG_MSD_MIN_VOLT:   cfg_in.msd_min_volt     = csr_pwdata[15:0];
            REG_NEG_WELD_VOLT:  cfg_in.neg_weld_volt    = csr_pwdata[15:0];
            REG_OPEN_VOLT:      cfg_in.open_volt        = csr_pwdata[15:0];
            REG_POS_WELD_VOLT:  cfg_in.pos_weld_volt    = csr_pwdata[15:0];
            REG_CHG_WELD_VOLT:  cfg_in.charge_weld_volt = csr_pwdata[15:0];
            REG_PRE_WELD_VOLT:  cfg_in.pre_weld_volt    = csr_pwdata[15:0];
            REG_POS_TEST_VOLT:  cfg_in.pos_test_volt    = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_DEBOUNCE_LIMIT: csr_prdata = {28'd0, cfg_ff.debounce_limit};
         REG_MSD_MIN_VOLT:   csr_prdata = {16'd0, cfg_ff.msd_min_volt};
         REG_NEG_WELD_VOLT:  csr_prdata = {16'd0, cfg_ff.neg_weld_volt};
         REG_OPEN_VOLT:      csr_prdata = {16'd0, cfg_ff.open_volt};
         REG_POS_WELD_VOLT:  csr_prdata = {16'd0, cfg_ff.pos_weld_volt};
         REG_CHG_WELD_VOLT:  csr_prdata = {16'd0, cfg_ff.charge_weld_volt};
         REG_PRE_WELD_VOLT:  csr_prdata = {16'd0, cfg_ff.pre_weld_volt};
         REG_POS_TEST_VOLT:  csr_prdata = {16'd0, cfg_ff.pos_test_volt};
         default:            csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_limit   <= 4'd12;
         cfg_ff.msd_min_volt     <= 16'd100;
         cfg_ff.neg_weld_volt    <= 16'd300;
         cfg_ff.open_volt        <= 16'd200;
         cfg_ff.pos_weld_volt    <= 16'd200;
         cfg_ff.charge_weld_volt <= 16'd300;
         cfg_ff.pre_weld_volt    <= 16'd200;
         cfg_ff.pos_test_volt    <= 16'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hdl/cfm_eval.sv
// Single-pass evaluation of one check tick: phase windows, debounce
// counters and status updates. Purely combinational; depends on cfm_pkg.
module cfm_eval
   import cfm_pkg::*;
(
   input  item_type  item,
   input  cfg_type   cfg,
   input  state_type cur,
   output state_type nxt
);

   always_comb begin
      qual_type   q;
      logic [3:0] lim;
      logic       cond;
      logic [7:0] sc;
      logic [15:0] t;
      nxt  = cur;
      q    = '0;
      lim  = cfg.debounce_limit;
      sc   = item.state_code;
      t    = item.elapsed_ms;
      cond = 1'b0;
      case (item.cmd)
         CMD_PART1: begin
            if (t <= T_PART1_END) begin
               q = qualify(cur.cnt[CNT_MSD], item.volt_v1 < cfg.msd_min_volt, lim);
               nxt.cnt[CNT_MSD] = q.cnt;
               if (q.hit) begin
                  nxt.fault_bits[F_MSD] = 1'b1;
                  nxt.stage             = STAGE_1;
                  nxt.power_off         = 1'b1;
               end
               q = qualify(cur.cnt[CNT_NWELD], item.volt_v2 >= cfg.neg_weld_volt, lim);
               nxt.cnt[CNT_NWELD] = q.cnt;
               if (q.hit) begin
                  nxt.fault_bits[F_NWELD] = 1'b1;
                  nxt.contactor[CT_NEG]   = 1'b1;
                  nxt.power_off           = 1'b1;
               end
            end else if (!cur.fault_bits[F_MSD] && !cur.fault_bits[F_NWELD]) begin
               nxt.stage = STAGE_1;
            end
         end
         CMD_PART2: begin
            if (t > T_WIN_START && t < T_PART2_END) begin
               q = qualify(cur.cnt[CNT_NOPEN], item.volt_v2 < cfg.open_volt, lim);
               nxt.cnt[CNT_NOPEN] = q.cnt;
               if (q.hit) begin
                  nxt.fault_bits[F_NOPEN] = 1'b1;
                  nxt.contactor[CT_NEG]   = 1'b0;
                  nxt.power_off           = 1'b1;
               end
               q = qualify(cur.cnt[CNT_PWELD],
                           item.volt_v3 > cfg.pos_weld_volt && sc == SC_POS_WELD, lim);
               nxt.cnt[CNT_PWELD] = q.cnt;
               if (q.hit) begin
                  nxt.fault_bits[F_PWELD] = 1'b1;
                  nxt.contactor[CT_POS]   = 1'b1;
                  nxt.power_off           = 1'b1;
               end
               q = qualify(cur.cnt[CNT_PANTWELD],
                           item.volt_v2b > cfg.charge_weld_volt && sc == SC_PANT_WELD, lim);
               nxt.cnt[CNT_PANTWELD] = q.cnt;
               if (q.hit) begin
                  nxt.fault_bits[F_PANTWELD] = 1'b1;
                  nxt.power_off              = 1'b1;
               end
               q = qualify(cur.cnt[CNT_DCWELD],
                           item.volt_v3b > cfg.charge_weld_volt && sc == SC_DC_WELD, lim);
               nxt.cnt[CNT_DCWELD] = q.cnt;
               if (q.hit) begin
                  nxt.fault_bits[F_DCWELD] = 1'b1;
                  nxt.power_off            = 1'b1;
               end
               // The stage check sees the faults latched on this same tick.
               if (t > T_MID && !nxt.fault_bits[F_NOPEN] &&
                   ((!nxt.fault_bits[F_PWELD] && sc == SC_POS_WELD) ||
                    (!nxt.fault_bits[F_PANTWELD] && sc == SC_PANT_WELD) ||
                    (!nxt.fault_bits[F_DCWELD] && sc == SC_DC_WELD))) begin
                  nxt.stage = STAGE_2;
               end
            end
         end
         CMD_PART3: begin
            if (t > T_WIN_START) begin
               if (t <= T_MID) begin
                  q = qualify(cur.cnt[CNT_POPEN],
                              item.volt_v3 < cfg.open_volt && sc == SC_POS_OPEN, lim);
                  nxt.cnt[CNT_POPEN] = q.cnt;
                  if (q.hit) begin
                     nxt.fault_bits[F_POPEN] = 1'b1;
                     nxt.contactor[CT_POS]   = 1'b0;
                     nxt.hv                  = HV_INVALID;
                     nxt.power_off           = 1'b1;
                  end
                  q = qualify(cur.cnt[CNT_PANTOPEN],
                              item.volt_v2b != 16'd0 && item.volt_v2b < cfg.open_volt &&
                              sc == SC_PANT_OPEN, lim);
                  nxt.cnt[CNT_PANTOPEN] = q.cnt;
                  if (q.hit) begin
                     nxt.fault_bits[F_PANTOPEN] = 1'b1;
                     nxt.hv                     = HV_INVALID;
                     nxt.power_off              = 1'b1;
                  end
                  q = qualify(cur.cnt[CNT_DCOPEN],
                              item.volt_v3b != 16'd0 && item.volt_v3b < cfg.open_volt &&
                              sc == SC_DC_OPEN, lim);
                  nxt.cnt[CNT_DCOPEN] = q.cnt;
                  if (q.hit) begin
                     nxt.fault_bits[F_DCOPEN] = 1'b1;
                     nxt.contactor[CT_POS]    = 1'b0;
                     nxt.hv                   = HV_INVALID;
                     nxt.power_off            = 1'b1;
                  end
               end else if ((!cur.fault_bits[F_POPEN] && sc == SC_POS_OPEN) ||
                            (!cur.fault_bits[F_PANTOPEN] && sc == SC_PANT_OPEN) ||
                            (!cur.fault_bits[F_DCOPEN] && sc == SC_DC_OPEN)) begin
                  nxt.stage = STAGE_3;
                  nxt.hv    = HV_NORMAL;
               end
            end
         end
         CMD_PRECHARGE: begin
            if (t >= T_WIN_START) begin
               cond = item.volt_v2 >= cfg.pre_weld_volt;
               q = qualify(cur.cnt[CNT_PRE], cond, lim);
               nxt.cnt[CNT_PRE] = q.cnt;
               if (q.hit) begin
                  nxt.fault_bits[F_PRE] = 1'b1;
                  nxt.contactor[CT_PRE] = 1'b1;
                  nxt.precharge         = PRE_WELD;
                  nxt.power_off         = 1'b1;
               end
               if (!cond) begin
                  nxt.precharge = PRE_PASSED;
               end
            end
         end
         CMD_POS_TEST: begin
            if (t >= T_WIN_START) begin
               cond = item.volt_v2 >= cfg.pos_test_volt;
               q = qualify(cur.cnt[CNT_PTEST], cond, lim);
               nxt.cnt[CNT_PTEST] = q.cnt;
               if (q.hit) begin
                  nxt.fault_bits[F_PWELD] = 1'b1;
                  nxt.contactor[CT_POS]   = 1'b1;
                  nxt.power_off           = 1'b1;
               end
               if (!cond) begin
                  nxt.stage = STAGE_1;
               end
            end
         end
         default: ;
      endcase
   end

endmodule

// File: hdl/contactor_fault_monitor_core.sv
// Top level of the contactor fault monitor: stream channels, beat
// registers and the diagnostic state. Depends on cfm_pkg, cfm_csr, cfm_eval.
//
// Usage: each req beat is one check tick (phase, elapsed time, pack state
// code, five voltage readings). Every accepted beat produces exactly one
// rsp beat carrying the sticky fault flags, power-off request, contactor
// status, self-check stage, precharge result and high-voltage status as
// they stand after that tick.
// A req beat is captured in an input register; the evaluation logic then
// updates the debounce counters and status and writes the rsp register once
// that register is free or being emptied. One beat per cycle is sustained
// while the receiver keeps rsp_tready high.
// When the receiver stalls, the rsp beat holds and the input register still
// takes one more beat; req_tready drops only when both are full.
// Reset clears all counters and status to zero, empties both registers and
// restores the thresholds to their defaults. Thresholds are to be written by
// the user over the csr port while the stream is idle; the block does not
// enforce this. pready is always high.
module contactor_fault_monitor_core
   import cfm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // Input stream.
   input  logic         req_tvalid,
   output logic         req_tready,
   // Fields from bit 0: cmd[2:0], elapsed_ms[18:3], state_code[26:19],
   // volt_v1[42:27], volt_v2[58:43], volt_v3[74:59], volt_v2b[90:75],
   // volt_v3b[106:91], zero padding[111:107].
   input  logic [111:0] req_tdata,
   // Result stream.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // Fields from bit 0: fault_flags[9:0], power_off_request[10],
   // contactor_status[14:11], selfcheck_stage[16:15],
   // precharge_check[18:17], hv_status[20:19], zero padding[23:21].
   output logic [23:0]  rsp_tdata,
   // Configuration port.
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   cfg_type     cfg;
   item_type    req_item;
   item_type    item_ff;
   logic        item_valid_ff;
   logic        item_valid_in;
   state_type   state_ff;
   state_type   state_in;
   state_type   state_nxt;
   logic [23:0] rsp_data_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        advance;
   logic        req_take;

   cfm_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .cfg        (cfg)
   );

   cfm_eval u_eval (
      .item(item_ff),
      .cfg (cfg),
      .cur (state_ff),
      .nxt (state_nxt)
   );

   // Unpack the input beat.
   assign req_item.cmd        = req_tdata[2:0];
   assign req_item.elapsed_ms = req_tdata[18:3];
   assign req_item.state_code = req_tdata[26:19];
   assign req_item.volt_v1    = req_tdata[42:27];
   assign req_item.volt_v2    = req_tdata[58:43];
   assign req_item.volt_v3    = req_tdata[74:59];
   assign req_item.volt_v2b   = req_tdata[90:75];
   assign req_item.volt_v3b   = req_tdata[106:91];

   // The held tick is evaluated when the result register is free or
   // being emptied in this cycle.
   assign advance    = item_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~item_valid_ff | advance;
   assign req_take   = req_tvalid & req_tready;

   assign item_valid_in = req_take | (item_valid_ff & ~advance);
   assign rsp_valid_in  = advance | (rsp_valid_ff & ~rsp_tready);
   assign state_in      = advance ? state_nxt : state_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_item;
      end
      if (advance) begin
         rsp_data_ff <= {3'd0, state_nxt.hv, state_nxt.precharge, state_nxt.stage,
                         state_nxt.contactor, state_nxt.power_off,
                         state_nxt.fault_bits};
      end
   end

endmodule

// File: sim/cfm_status_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the contactor fault monitor: watches the req, rsp and csr ports,
// predicts the status beat of every tick and compares it with the rsp beat.
// Depends on cfm_pkg for the beat, configuration and code definitions.
module cfm_status_checker
   import cfm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [111:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [23:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int unsigned  mismatches,
   output int unsigned  outstanding,
   output int unsigned  checked
);

   typedef struct packed {
      logic [9:0] faults;
      logic       power_off;
      logic [3:0] contactor;
      logic [1:0] stage;
      logic [1:0] precharge;
      logic [1:0] hv;
   } status_type;

   cfg_type    thresholds;
   logic [4:0] debounce_cnt [NUM_CNT];
   status_type live_status;
   status_type expected_status_q [$];

   // A failing condition clears the slot; reaching the limit latches the
   // power-off request and parks the slot one above the limit.
   function automatic logic debounce_step(input int idx, input logic cond);
      logic [4:0] bumped;
      if (!cond) begin
         debounce_cnt[idx] = 5'd0;
         return 1'b0;
      end
      bumped = debounce_cnt[idx] + 5'd1;
      if (bumped >= {1'b0, thresholds.debounce_limit}) begin
         debounce_cnt[idx] = {1'b0, thresholds.debounce_limit} + 5'd1;
         live_status.power_off = 1'b1;
         return 1'b1;
      end
      debounce_cnt[idx] = bumped;
      return 1'b0;
   endfunction

   task automatic advance_tick(input item_type tk);
      logic cond;
      case (tk.cmd)
         CMD_PART1: begin
            if (tk.elapsed_ms <= T_PART1_END) begin
               if (debounce_step(CNT_MSD, tk.volt_v1 < thresholds.msd_min_volt)) begin
                  live_status.faults[F_MSD] = 1'b1;
                  live_status.stage = STAGE_1;
               end
               if (debounce_step(CNT_NWELD, tk.volt_v2 >= thresholds.neg_weld_volt)) begin
                  live_status.faults[F_NWELD] = 1'b1;
                  live_status.contactor[CT_NEG] = 1'b1;
               end
            end else if (!live_status.faults[F_MSD] && !live_status.faults[F_NWELD]) begin
               live_status.stage = STAGE_1;
            end
         end
         CMD_PART2: begin
            if (tk.elapsed_ms > T_WIN_START && tk.elapsed_ms < T_PART2_END) begin
               if (debounce_step(CNT_NOPEN, tk.volt_v2 < thresholds.open_volt)) begin
                  live_status.faults[F_NOPEN] = 1'b1;
                  live_status.contactor[CT_NEG] = 1'b0;
               end
               if (debounce_step(CNT_PWELD, tk.volt_v3 > thresholds.pos_weld_volt &&
                                 tk.state_code == SC_POS_WELD)) begin
                  live_status.faults[F_PWELD] = 1'b1;
                  live_status.contactor[CT_POS] = 1'b1;
               end
               if (debounce_step(CNT_PANTWELD, tk.volt_v2b > thresholds.charge_weld_volt &&
                                 tk.state_code == SC_PANT_WELD))
                  live_status.faults[F_PANTWELD] = 1'b1;
               if (debounce_step(CNT_DCWELD, tk.volt_v3b > thresholds.charge_weld_volt &&
                                 tk.state_code == SC_DC_WELD))
                  live_status.faults[F_DCWELD] = 1'b1;
               // The stage check sees the weld faults as updated by this tick.
               if (tk.elapsed_ms > T_MID && !live_status.faults[F_NOPEN] &&
                   ((!live_status.faults[F_PWELD] && tk.state_code == SC_POS_WELD) ||
                    (!live_status.faults[F_PANTWELD] && tk.state_code == SC_PANT_WELD) ||
                    (!live_status.faults[F_DCWELD] && tk.state_code == SC_DC_WELD)))
                  live_status.stage = STAGE_2;
            end
         end
         CMD_PART3: begin
            if (tk.elapsed_ms > T_WIN_START) begin
               if (tk.elapsed_ms <= T_MID) begin
                  if (debounce_step(CNT_POPEN, tk.volt_v3 < thresholds.open_volt &&
                                    tk.state_code == SC_POS_OPEN)) begin
                     live_status.faults[F_POPEN] = 1'b1;
                     live_status.contactor[CT_POS] = 1'b0;
                     live_status.hv = HV_INVALID;
                  end
                  if (debounce_step(CNT_PANTOPEN, tk.volt_v2b != 16'd0 &&
                                    tk.volt_v2b < thresholds.open_volt &&
                                    tk.state_code == SC_PANT_OPEN)) begin
                     live_status.faults[F_PANTOPEN] = 1'b1;
                     live_status.hv = HV_INVALID;
                  end
                  if (debounce_step(CNT_DCOPEN, tk.volt_v3b != 16'd0 &&
                                    tk.volt_v3b < thresholds.open_volt &&
                                    tk.state_code == SC_DC_OPEN)) begin
                     live_status.faults[F_DCOPEN] = 1'b1;
                     live_status.contactor[CT_POS] = 1'b0;
                     live_status.hv = HV_INVALID;
                  end
               end else if ((!live_status.faults[F_POPEN] && tk.state_code == SC_POS_OPEN) ||
                            (!live_status.faults[F_PANTOPEN] &&
                             tk.state_code == SC_PANT_OPEN) ||
                            (!live_status.faults[F_DCOPEN] && tk.state_code == SC_DC_OPEN)) begin
                  live_status.stage = STAGE_3;
                  live_status.hv = HV_NORMAL;
               end
            end
         end
         CMD_PRECHARGE: begin
            if (tk.elapsed_ms >= T_WIN_START) begin
               cond = tk.volt_v2 >= thresholds.pre_weld_volt;
               if (debounce_step(CNT_PRE, cond)) begin
                  live_status.faults[F_PRE] = 1'b1;
                  live_status.contactor[CT_PRE] = 1'b1;
                  live_status.precharge = PRE_WELD;
               end
               if (!cond)
                  live_status.precharge = PRE_PASSED;
            end
         end
         CMD_POS_TEST: begin
            if (tk.elapsed_ms >= T_WIN_START) begin
               cond = tk.volt_v2 >= thresholds.pos_test_volt;
               if (debounce_step(CNT_PTEST, cond)) begin
                  live_status.faults[F_PWELD] = 1'b1;
                  live_status.contactor[CT_POS] = 1'b1;
               end
               if (!cond)
                  live_status.stage = STAGE_1;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      item_type   tk;
      status_type got;
      status_type want;
      if (reset) begin
         thresholds.debounce_limit   = 4'd12;
         thresholds.msd_min_volt     = 16'd100;
         thresholds.neg_weld_volt    = 16'd300;
         thresholds.open_volt        = 16'd200;
         thresholds.pos_weld_volt    = 16'd200;
         thresholds.charge_weld_volt = 16'd300;
         thresholds.pre_weld_volt    = 16'd200;
         thresholds.pos_test_volt    = 16'd100;
         for (int i = 0; i < NUM_CNT; i++)
            debounce_cnt[i] = 5'd0;
         live_status = '0;
         expected_status_q.delete();
         mismatches = 0;
         checked = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.faults    = rsp_tdata[9:0];
            got.power_off = rsp_tdata[10];
            got.contactor = rsp_tdata[14:11];
            got.stage     = rsp_tdata[16:15];
            got.precharge = rsp_tdata[18:17];
            got.hv        = rsp_tdata[20:19];
            checked++;
            if (expected_status_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: rsp beat %h arrived with no tick pending", $time,
                           rsp_tdata);
            end else begin
               want = expected_status_q.pop_front();
               if (got.faults !== want.faults || got.power_off !== want.power_off ||
                   got.contactor !== want.contactor || got.stage !== want.stage ||
                   got.precharge !== want.precharge || got.hv !== want.hv) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("%0t: beat %0d expected faults=%h poff=%b ct=%h stage=%0d ",
                            $time, checked, want.faults, want.power_off,
                            want.contactor, want.stage);
                     $write("pre=%0d hv=%0d, got faults=%h poff=%b ct=%h ",
                            want.precharge, want.hv, got.faults, got.power_off,
                            got.contactor);
                     $display("stage=%0d pre=%0d hv=%0d", got.stage, got.precharge,
                              got.hv);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            tk.cmd        = req_tdata[2:0];
            tk.elapsed_ms = req_tdata[18:3];
            tk.state_code = req_tdata[26:19];
            tk.volt_v1    = req_tdata[42:27];
            tk.volt_v2    = req_tdata[58:43];
            tk.volt_v3    = req_tdata[74:59];
            tk.volt_v2b   = req_tdata[90:75];
            tk.volt_v3b   = req_tdata[106:91];
            advance_tick(tk);
            expected_status_q.push_back(live_status);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_DEBOUNCE_LIMIT: thresholds.debounce_limit   = csr_pwdata[3:0];
               REG_MSD_MIN_VOLT:   thresholds.msd_min_volt     = csr_pwdata[15:0];
               REG_NEG_WELD_VOLT:  thresholds.neg_weld_volt    = csr_pwdata[15:0];
               REG_OPEN_VOLT:      thresholds.open_volt        = csr_pwdata[15:0];
               REG_POS_WELD_VOLT:  thresholds.pos_weld_volt    = csr_pwdata[15:0];
               REG_CHG_WELD_VOLT:  thresholds.charge_weld_volt = csr_pwdata[15:0];
               REG_PRE_WELD_VOLT:  thresholds.pre_weld_volt    = csr_pwdata[15:0];
               REG_POS_TEST_VOLT:  thresholds.pos_test_volt    = csr_pwdata[15:0];
               default: ;
            endcase
         end
      end
      outstanding = expected_status_q.size();
   end

endmodule

// File: sim/tb_contactor_fault_monitor_core.sv
`timescale 1ns / 100ps
// Top of the contactor fault monitor testbench: clock, reset, tick and threshold
// stimulus and the verdict. Depends on cfm_pkg, cfm_status_checker and the block.
module tb_contactor_fault_monitor_core;
   import cfm_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [23:0]  rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [4:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   int unsigned  mismatches;
   int unsigned  outstanding;
   int unsigned  checked;

   // Stimulus bookkeeping. The threshold copy lets the generator aim readings
   // just below, at and just above whatever limits are currently loaded.
   cfg_type      cur_cfg;
   int unsigned  ticks_sent = 0;
   int unsigned  settings_count = 1;
   logic         gaps_enable = 1'b0;
   logic         stall_enable = 1'b0;
   int unsigned  rsp_hold = 0;

   contactor_fault_monitor_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   cfm_status_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked)
   );

   // 12 ns period clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Gap lengths: mostly short, now and then a long stretch.
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 7)
         return $urandom_range(1, 3);
      else if (r < 9)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Receiver back-pressure. All inputs change on the falling edge so that the
   // block and the checker see settled values at the rising edge. Each falling
   // edge makes exactly one assignment to rsp_tready.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (stall_enable && $urandom_range(0, 5) == 0) begin
         rsp_hold <= gap_len() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // A reading aimed at one threshold: the rails, the threshold and its
   // neighbors, either side of it, or anything at all.
   function automatic logic [15:0] pick_volt(input logic [15:0] thr);
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return thr - 16'd1;
         3: return thr;
         4: return thr + 16'd1;
         5, 6: return (thr == 16'd0) ? 16'd0 : 16'($urandom_range(0, thr - 16'd1));
         7: return (thr == 16'hFFFF) ? thr : 16'($urandom_range(thr + 16'd1, 65535));
         default: return 16'($urandom);
      endcase
   endfunction

   // Pack state codes: mostly the ones the phase cares about.
   function automatic logic [7:0] pick_state(input logic [2:0] cmd);
      int unsigned sel;
      sel = $urandom_range(0, 2);
      if ($urandom_range(0, 9) < 2)
         return 8'($urandom);
      if (cmd == CMD_PART3)
         return (sel == 0) ? SC_POS_OPEN : (sel == 1) ? SC_PANT_OPEN : SC_DC_OPEN;
      return (sel == 0) ? SC_POS_WELD : (sel == 1) ? SC_PANT_WELD : SC_DC_WELD;
   endfunction

   function automatic item_type make_tick(input logic [2:0] cmd, input logic [15:0] t,
                                          input logic [7:0] sc, input logic [15:0] v1,
                                          input logic [15:0] v2, input logic [15:0] v3,
                                          input logic [15:0] v2b, input logic [15:0] v3b);
      item_type tk;
      tk.cmd        = cmd;
      tk.elapsed_ms = t;
      tk.state_code = sc;
      tk.volt_v1    = v1;
      tk.volt_v2    = v2;
      tk.volt_v3    = v3;
      tk.volt_v2b   = v2b;
      tk.volt_v3b   = v3b;
      return tk;
   endfunction

   // Offer one tick beat, optionally after an idle gap, and hold it until the
   // block takes it. tvalid stays high between back-to-back beats.
   task automatic send_beat(input item_type tk);
      int unsigned n;
      n = (gaps_enable && $urandom_range(0, 3) == 0) ? gap_len() : 0;
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, tk.volt_v3b, tk.volt_v2b, tk.volt_v3, tk.volt_v2, tk.volt_v1,
                     tk.state_code, tk.elapsed_ms, tk.cmd};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      ticks_sent++;
   endtask

   // Stop offering beats and wait for every predicted status beat to arrive.
   // Sampling at the falling edge keeps clear of the checker's update.
   task automatic stop_and_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Load a full threshold set. Every tick yields a status beat, so once the
   // last one is in the block is idle and the registers can change.
   task automatic set_thresholds(input logic [3:0] limit, input logic [15:0] msd,
                                 input logic [15:0] nweld, input logic [15:0] open,
                                 input logic [15:0] pweld, input logic [15:0] cweld,
                                 input logic [15:0] preweld, input logic [15:0] ptest);
      stop_and_drain();
      write_reg(REG_DEBOUNCE_LIMIT, {12'd0, limit});
      write_reg(REG_MSD_MIN_VOLT, msd);
      write_reg(REG_NEG_WELD_VOLT, nweld);
      write_reg(REG_OPEN_VOLT, open);
      write_reg(REG_POS_WELD_VOLT, pweld);
      write_reg(REG_CHG_WELD_VOLT, cweld);
      write_reg(REG_PRE_WELD_VOLT, preweld);
      write_reg(REG_POS_TEST_VOLT, ptest);
      cur_cfg.debounce_limit   = limit;
      cur_cfg.msd_min_volt     = msd;
      cur_cfg.neg_weld_volt    = nweld;
      cur_cfg.open_volt        = open;
      cur_cfg.pos_weld_volt    = pweld;
      cur_cfg.charge_weld_volt = cweld;
      cur_cfg.pre_weld_volt    = preweld;
      cur_cfg.pos_test_volt    = ptest;
      settings_count++;
   endtask

   // Random traffic in bursts. A burst keeps one phase, one pack state and a
   // base reading per channel, so debounce runs build up long enough to latch;
   // a few readings wander each tick to break runs. About four bursts in ten
   // follow on from the previous phase with the clock restarted at zero, which
   // walks the power-up sequence part 1, part 2, part 3, precharge, positive.
   task automatic run_bursts(input int unsigned n_items);
      item_type    tk;
      int unsigned sent;
      int unsigned len;
      int          te;
      logic [2:0]  cmd;
      logic [2:0]  prev;
      logic [15:0] v2_thr;
      logic [15:0] side_thr;
      logic [15:0] b1, b2, b3, b2b, b3b;
      logic [7:0]  sc;
      sent = 0;
      prev = CMD_POS_TEST;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) < 4) begin
            cmd = (prev >= CMD_POS_TEST) ? CMD_PART1 : prev + 3'd1;
            te  = 0;
         end else begin
            cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
            te  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535))
                                              : int'($urandom_range(0, 450));
         end
         case (cmd)
            CMD_PART1:     v2_thr = cur_cfg.neg_weld_volt;
            CMD_PRECHARGE: v2_thr = cur_cfg.pre_weld_volt;
            CMD_POS_TEST:  v2_thr = cur_cfg.pos_test_volt;
            default:       v2_thr = cur_cfg.open_volt;
         endcase
         side_thr = (cmd == CMD_PART2) ? cur_cfg.charge_weld_volt : cur_cfg.open_volt;
         sc  = pick_state(cmd);
         b1  = pick_volt(cur_cfg.msd_min_volt);
         b2  = pick_volt(v2_thr);
         b3  = pick_volt((cmd == CMD_PART2) ? cur_cfg.pos_weld_volt : cur_cfg.open_volt);
         b2b = pick_volt(side_thr);
         b3b = pick_volt(side_thr);
         len = $urandom_range(1, 24);
         // Some bursts run with no idling on either side at all.
         gaps_enable  = ($urandom_range(0, 3) != 0);
         stall_enable = ($urandom_range(0, 3) != 0);
         for (int k = 0; k < len && sent < n_items; k++) begin
            if ($urandom_range(0, 19) < 3) b1 = pick_volt(cur_cfg.msd_min_volt);
            if ($urandom_range(0, 19) < 3) b2 = pick_volt(v2_thr);
            if ($urandom_range(0, 19) < 3) b3 = pick_volt(cur_cfg.open_volt);
            if ($urandom_range(0, 19) < 3) b2b = pick_volt(side_thr);
            if ($urandom_range(0, 19) < 3) b3b = pick_volt(side_thr);
            tk = make_tick(cmd, 16'(te), sc, b1, b2, b3, b2b, b3b);
            send_beat(tk);
            sent++;
            te = te + int'($urandom_range(0, 40));
            if (te > 65535)
               te = 65535;
            // Occasionally hold off until the result stream has fully caught up.
            if ($urandom_range(0, 149) == 0)
               stop_and_drain();
         end
         prev = cmd;
      end
   endtask

   initial begin
      cur_cfg.debounce_limit   = 4'd12;
      cur_cfg.msd_min_volt     = 16'd100;
      cur_cfg.neg_weld_volt    = 16'd300;
      cur_cfg.open_volt        = 16'd200;
      cur_cfg.pos_weld_volt    = 16'd200;
      cur_cfg.charge_weld_volt = 16'd300;
      cur_cfg.pre_weld_volt    = 16'd200;
      cur_cfg.pos_test_volt    = 16'd100;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed ticks against the reset thresholds: window edges of every
      // phase, each relevant pack state, the zero-volt exclusion in the SC_PANT_OPEN
      // check, unused phase codes and all-zero / all-one fields.
      send_beat(make_tick(CMD_PART1, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      send_beat(make_tick(CMD_PART1, T_PART1_END, 8'd0, 16'hFFFF, 16'hFFFF, 16'd0,
                          16'd0, 16'd0));
      send_beat(make_tick(CMD_PART1, T_PART1_END + 16'd1, 8'd0, 16'd0, 16'd0, 16'd0,
                          16'd0, 16'd0));
      send_beat(make_tick(CMD_PART2, T_WIN_START, SC_POS_WELD, 16'd0, 16'd0, 16'hFFFF,
                          16'd0, 16'd0));
      send_beat(make_tick(CMD_PART2, T_WIN_START + 16'd1, SC_POS_WELD, 16'd0, 16'd500,
                          16'd0, 16'd0, 16'd0));
      send_beat(make_tick(CMD_PART2, T_MID + 16'd1, SC_POS_WELD, 16'd0, 16'd500, 16'd0,
                          16'd0, 16'd0));
      send_beat(make_tick(CMD_PART2, T_PART2_END - 16'd1, SC_PANT_WELD, 16'd0, 16'd500,
                          16'd0, 16'hFFFF, 16'd0));
      send_beat(make_tick(CMD_PART2, T_PART2_END, SC_DC_WELD, 16'd0, 16'd0, 16'd0,
                          16'd0, 16'hFFFF));
      send_beat(make_tick(CMD_PART2, 16'd450, SC_DC_WELD, 16'd0, 16'd199, 16'd0, 16'd0,
                          16'd301));
      send_beat(make_tick(CMD_PART3, T_WIN_START, SC_POS_OPEN, 16'd0, 16'd0, 16'd0,
                          16'd0, 16'd0));
      send_beat(make_tick(CMD_PART3, T_WIN_START + 16'd1, SC_POS_OPEN, 16'd0, 16'd0,
                          16'd0, 16'd0, 16'd0));
      send_beat(make_tick(CMD_PART3, T_MID, SC_PANT_OPEN, 16'd0, 16'd0, 16'd0, 16'd0,
                          16'd0));
      send_beat(make_tick(CMD_PART3, T_MID, SC_PANT_OPEN, 16'd0, 16'd0, 16'd0, 16'd1,
                          16'd0));
      send_beat(make_tick(CMD_PART3, 16'd200, SC_DC_OPEN, 16'd0, 16'd0, 16'd0, 16'd0,
                          16'd199));
      send_beat(make_tick(CMD_PART3, T_MID + 16'd1, SC_POS_OPEN, 16'd0, 16'd0, 16'd0,
                          16'd0, 16'd0));
      send_beat(make_tick(CMD_PART3, 16'hFFFF, SC_PANT_OPEN, 16'd0, 16'd0, 16'd0, 16'd0,
                          16'd0));
      send_beat(make_tick(CMD_PRECHARGE, T_WIN_START - 16'd1, 8'd0, 16'd0, 16'hFFFF,
                          16'd0, 16'd0, 16'd0));
      send_beat(make_tick(CMD_PRECHARGE, T_WIN_START, 8'd0, 16'd0, 16'd199, 16'd0,
                          16'd0, 16'd0));
      send_beat(make_tick(CMD_PRECHARGE, 16'd1000, 8'd0, 16'd0, 16'd200, 16'd0, 16'd0,
                          16'd0));
      send_beat(make_tick(CMD_POS_TEST, T_WIN_START, 8'd0, 16'd0, 16'd99, 16'd0, 16'd0,
                          16'd0));
      send_beat(make_tick(CMD_POS_TEST, T_WIN_START, 8'd0, 16'd0, 16'hFFFF, 16'd0,
                          16'd0, 16'd0));
      send_beat(make_tick(3'd5, 16'd100, 8'd17, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF));
      send_beat(make_tick(3'd6, 16'd100, 8'd87, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF));
      send_beat(make_tick(3'd7, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF));

      // Random phases, each under a different threshold set.
      run_bursts(150);
      set_thresholds(4'd15, 16'($urandom_range(50, 800)), 16'($urandom_range(50, 800)),
                     16'($urandom_range(50, 800)), 16'($urandom_range(50, 800)),
                     16'($urandom_range(50, 800)), 16'($urandom_range(50, 800)),
                     16'($urandom_range(50, 800)));
      run_bursts(150);
      set_thresholds(4'd1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
      run_bursts(150);
      set_thresholds(4'd3, 16'($urandom_range(50, 800)), 16'($urandom_range(50, 800)),
                     16'($urandom_range(50, 800)), 16'($urandom_range(50, 800)),
                     16'($urandom_range(50, 800)), 16'($urandom_range(50, 800)),
                     16'($urandom_range(50, 800)));
      run_bursts(150);

      // A debounce limit of zero latches on the very first qualifying tick.
      set_thresholds(4'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
      send_beat(make_tick(CMD_PRECHARGE, 16'd100, 8'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0,
                          16'd0));
      send_beat(make_tick(CMD_PRECHARGE, 16'd100, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                          16'd0));
      send_beat(make_tick(CMD_PART2, 16'd100, SC_DC_WELD, 16'd0, 16'd0, 16'd0, 16'd0,
                          16'hFFFF));
      send_beat(make_tick(CMD_PART1, 16'd10, 8'd0, 16'd0, 16'd5, 16'd0, 16'd0, 16'd0));
      run_bursts(100);

      set_thresholds(4'($urandom_range(1, 15)), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
      run_bursts(150);
      set_thresholds(4'd2, 16'd100, 16'd300, 16'd200, 16'd200, 16'd300, 16'd200, 16'd100);
      run_bursts(50);

      // Let the last status beats come out, then let the clock run on with no traffic.
      stop_and_drain();
      gaps_enable  = 1'b0;
      stall_enable = 1'b0;
      repeat (8) @(posedge clock);

      $display("summary: %0d ticks over %0d threshold settings, %0d status beats checked",
               ticks_sent, settings_count, checked);
      $display("summary: power-up sequences and random bursts through all phases, limits 0..15");
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
